### hw/rtl/bisc_pkg.sv
package bisc_pkg;

  localparam int MaxRowsDef  = 256;
  localparam int MaxColsDef  = 256;
  localparam int FracBitsDef = 16;

  localparam int WtInBits  = 16;
  localparam int WtOutBits = 14;

  localparam logic [2:0] REG_SOURCE_ROWS   = 3'd0;
  localparam logic [2:0] REG_SOURCE_COLS   = 3'd1;
  localparam logic [2:0] REG_ROW_STEP      = 3'd2;
  localparam logic [2:0] REG_COL_STEP      = 3'd3;
  localparam logic [2:0] REG_THREE_CHANNEL = 3'd4;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // signed weight, 14 fraction bits, range about -0.08 .. 1.0
  typedef logic signed [16:0] wt_t;

  typedef struct packed {
    wt_t w0;
    wt_t w1;
    wt_t w2;
    wt_t w3;
  } wt_set_t;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       in_win;
  } result_t;

endpackage

### hw/rtl/bicubic_image_scaler_unit.sv
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | in_tuser=cmd, in_tdata=row,col,chan0..2
// out_    | out | out_tvalid/out_tready| out_tdata=chan0..2, out_tuser=inside_res
// cfg_    | in  | cfg_we               | cfg_index, cfg_data
//
// write transaction: stored in the source memory when row and col are in range
// compute transaction: a map multiply, the weight pipeline, 16 reads from the
//   single-read-port source memory and an accumulate drain produce the result;
//   next transaction taken once idle again; a window outside the image skips the reads
// reset clears control state only; source memory contents start undefined
// a result waits in the output register while the next transaction is taken; the
//   core holds a later result, and stalls its input, until that register is free
module bicubic_image_scaler_unit
  import bisc_pkg::*;
#(
  parameter int MAX_ROWS  = MaxRowsDef,
  parameter int MAX_COLS  = MaxColsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row, col, chan0_in, chan1_in, chan2_in
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // chan0_out, chan1_out, chan2_out
  output logic        out_tuser,  // inside_res
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [8:0]  source_rows_r, source_cols_r;
  logic [23:0] row_step_r, col_step_r;
  logic        three_channel_r;
  logic        start, busy, done;
  logic        res_hold;
  result_t     res;
  logic        ov_r;
  logic [23:0] od_r;
  logic        ou_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_rows_r   <= 9'd256;
      source_cols_r   <= 9'd256;
      row_step_r      <= 24'd131072;
      col_step_r      <= 24'd131072;
      three_channel_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_ROWS:   source_rows_r   <= cfg_data[8:0];
        REG_SOURCE_COLS:   source_cols_r   <= cfg_data[8:0];
        REG_ROW_STEP:      row_step_r      <= cfg_data;
        REG_COL_STEP:      col_step_r      <= cfg_data;
        REG_THREE_CHANNEL: three_channel_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the core takes a transaction whenever it is idle
  assign in_tready = !busy;
  assign start = in_tvalid && in_tready;
  // output register full and not drained this cycle
  assign res_hold = ov_r && !out_tready;

  bisc_core #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .start(start), .cmd(in_tuser),
    .row(in_tdata[11:0]), .col(in_tdata[23:12]), .pix(in_tdata[47:24]),
    .source_rows(source_rows_r), .source_cols(source_cols_r),
    .row_step(row_step_r), .col_step(col_step_r), .three_channel(three_channel_r),
    .res_hold(res_hold), .busy(busy), .done(done), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (done) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (done) begin
      od_r <= {res.c2, res.c1, res.c0};
      ou_r <= res.in_win;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule

### hw/rtl/bisc_weight.sv
// keys weights from a 16-bit fraction, three registered steps
module bisc_weight
  import bisc_pkg::*;
(
  input  logic          clk,
  input  logic          start,
  input  logic [15:0]   t,
  output wt_set_t       w
);

  localparam int Sh = 3 * WtInBits + 1 - WtOutBits;

  logic [15:0]        t1_r;
  logic [31:0]        t2_r;
  logic [47:0]        t3_r;
  logic [47:0]        t2u_r;
  logic [47:0]        tuu_r;
  logic signed [51:0] n0, n1, n2, n3;
  wt_set_t            w_r;

  function automatic wt_t rnd(input logic signed [51:0] n);
    logic signed [51:0] v;
    begin
      v = n + (52'sd1 <<< (Sh - 1));
      rnd = wt_t'(v >>> Sh);
    end
  endfunction

  always_ff @(posedge clk) begin
    t1_r  <= t;
    t2_r  <= 32'(t) * 32'(t);
    t3_r  <= 48'(t2_r) * 48'(t1_r);
    t2u_r <= {t2_r, 16'b0};
    tuu_r <= {t1_r, 32'b0};
    if (start) begin
      w_r.w0 <= rnd(n0);
      w_r.w1 <= rnd(n1);
      w_r.w2 <= rnd(n2);
      w_r.w3 <= rnd(n3);
    end
  end

  always_comb begin
    n0 = -$signed({4'b0, t3_r}) + ($signed({4'b0, t2u_r}) <<< 1) - $signed({4'b0, tuu_r});
    n1 = 52'sd3 * $signed({4'b0, t3_r}) - 52'sd5 * $signed({4'b0, t2u_r})
         + (52'sd1 <<< 49);
    n2 = -52'sd3 * $signed({4'b0, t3_r}) + ($signed({4'b0, t2u_r}) <<< 2)
         + $signed({4'b0, tuu_r});
    n3 = $signed({4'b0, t3_r}) - $signed({4'b0, t2u_r});
  end

  assign w = w_r;

endmodule

### hw/rtl/bisc_core.sv
// address sequencing, source memory and multiply-accumulate
module bisc_core
  import bisc_pkg::*;
#(
  parameter int MAX_ROWS  = MaxRowsDef,
  parameter int MAX_COLS  = MaxColsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         cmd,
  input  logic [11:0]  row,
  input  logic [11:0]  col,
  input  logic [23:0]  pix,
  input  logic [8:0]   source_rows,
  input  logic [8:0]   source_cols,
  input  logic [23:0]  row_step,
  input  logic [23:0]  col_step,
  input  logic         three_channel,
  input  logic         res_hold,
  output logic         busy,
  output logic         done,
  output result_t      res
);

  localparam int RowW  = $clog2(MAX_ROWS);
  localparam int ColW  = $clog2(MAX_COLS);
  localparam int AddrW = RowW + ColW;
  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int CoordW = 36;
  localparam int IntW  = CoordW - FRAC_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAP  = 3'd1;
  localparam logic [2:0] ST_WGT  = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [23:0] mem [Depth];
  logic [23:0] rd_r;

  logic [2:0]  st_r, st_nxt;
  logic [11:0] row_r, col_r;
  logic [CoordW-1:0] ry_r, cx_r;
  logic [2:0]  wcnt_r;
  logic [4:0]  idx_r;
  logic        rd_v_r;
  logic [3:0]  rd_idx_r;
  logic [RowW-1:0] rb_r;
  logic [ColW-1:0] cb_r;

  logic [15:0] tr, tc;
  wt_set_t     wr, wc;

  logic [IntW-1:0] ri, ci;
  logic [12:0] rows_eff, cols_eff;
  logic        in_win;

  // stage after read: weight product
  logic signed [33:0] wprod_r;
  logic [23:0]        pix_r;
  logic               mv_r, mlast_r;
  logic signed [43:0] acc0_r, acc1_r, acc2_r;
  logic               last_r;

  always_comb begin
    if (FRAC_BITS >= WtInBits) begin
      tr = 16'(ry_r[FRAC_BITS-1:0] >> (FRAC_BITS - WtInBits));
      tc = 16'(cx_r[FRAC_BITS-1:0] >> (FRAC_BITS - WtInBits));
    end else begin
      tr = 16'(ry_r[FRAC_BITS-1:0]) << (WtInBits - FRAC_BITS);
      tc = 16'(cx_r[FRAC_BITS-1:0]) << (WtInBits - FRAC_BITS);
    end
    ri = ry_r[CoordW-1:FRAC_BITS];
    ci = cx_r[CoordW-1:FRAC_BITS];
    rows_eff = (13'(source_rows) < 13'(MAX_ROWS)) ? 13'(source_rows) : 13'(MAX_ROWS);
    cols_eff = (13'(source_cols) < 13'(MAX_COLS)) ? 13'(source_cols) : 13'(MAX_COLS);
    in_win = (ri != '0) && ((ri + IntW'(2)) < IntW'(rows_eff))
             && (ci != '0) && ((ci + IntW'(2)) < IntW'(cols_eff));
  end

  bisc_weight u_wr (.clk(clk), .start(st_r == ST_WGT && wcnt_r == 3'd3), .t(tr), .w(wr));
  bisc_weight u_wc (.clk(clk), .start(st_r == ST_WGT && wcnt_r == 3'd3), .t(tc), .w(wc));

  function automatic wt_t pick(input wt_set_t s, input logic [1:0] k);
    unique case (k)
      2'd0: pick = s.w0;
      2'd1: pick = s.w1;
      2'd2: pick = s.w2;
      default: pick = s.w3;
    endcase
  endfunction

  // memory: one write port, one read port, registered read
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic [RowW-1:0]   rr;
  logic [ColW-1:0]   rc;
  assign wr_en   = start && cmd == CMD_WRITE && 13'(row) < 13'(MAX_ROWS)
                   && 13'(col) < 13'(MAX_COLS);
  assign wr_addr = {row[RowW-1:0], col[ColW-1:0]};
  assign rr      = rb_r + RowW'(idx_r[3:2]);
  assign rc      = cb_r + ColW'(idx_r[1:0]);
  assign rd_addr = {rr, rc};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= pix;
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (start && cmd == CMD_COMPUTE) st_nxt = ST_MAP;
      ST_MAP:  st_nxt = ST_WGT;
      ST_WGT:  if (wcnt_r == 3'd3) st_nxt = in_win ? ST_RUN : ST_FIN;
      ST_RUN:  if (idx_r == 5'd15) st_nxt = ST_FIN;
      // result waits here for the last accumulate and while the output register is held
      ST_FIN:  if ((!in_win || last_r) && !res_hold) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rd_v_r <= 1'b0;
      mv_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rd_v_r <= (st_r == ST_RUN);
      mv_r <= rd_v_r;
      last_r <= (st_r == ST_IDLE) ? 1'b0 : (last_r || (mv_r && mlast_r));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row_r <= row;
      col_r <= col;
    end
    if (st_r == ST_MAP) begin
      ry_r <= CoordW'(row_r) * CoordW'(row_step);
      cx_r <= CoordW'(col_r) * CoordW'(col_step);
      wcnt_r <= '0;
    end
    if (st_r == ST_WGT) begin
      wcnt_r <= wcnt_r + 3'd1;
      idx_r <= '0;
      rb_r <= RowW'(ri - 1);
      cb_r <= ColW'(ci - 1);
    end
    if (st_r == ST_RUN) idx_r <= idx_r + 5'd1;
    rd_idx_r <= idx_r[3:0];
    pix_r <= rd_r;
    mlast_r <= (rd_idx_r == 4'd15);
    wprod_r <= 34'(pick(wr, rd_idx_r[3:2])) * 34'(pick(wc, rd_idx_r[1:0]));
    if (st_r == ST_WGT) begin
      acc0_r <= '0;
      acc1_r <= '0;
      acc2_r <= '0;
    end else if (mv_r) begin
      acc0_r <= acc0_r + 44'(wprod_r) * $signed({36'b0, pix_r[7:0]});
      acc1_r <= acc1_r + 44'(wprod_r) * $signed({36'b0, pix_r[15:8]});
      acc2_r <= acc2_r + 44'(wprod_r) * $signed({36'b0, pix_r[23:16]});
    end
  end

  function automatic logic [7:0] sat(input logic signed [43:0] a);
    logic [43:0] r;
    begin
      r = 44'(a) + (44'd1 << (2 * WtOutBits - 1));
      if (a < 0) sat = 8'd0;
      else if ((r >> (2 * WtOutBits)) > 44'd255) sat = 8'd255;
      else sat = r[2*WtOutBits +: 8];
    end
  endfunction

  assign busy = (st_r != ST_IDLE);
  assign done = (st_r == ST_FIN) && (!in_win || last_r) && !res_hold;
  always_comb begin
    res.in_win = in_win;
    res.c0 = in_win ? sat(acc0_r) : 8'd0;
    res.c1 = (in_win && three_channel) ? sat(acc1_r) : 8'd0;
    res.c2 = (in_win && three_channel) ? sat(acc2_r) : 8'd0;
  end

endmodule

### hw/rtl/bisc_checker.sv
module bisc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tuser,
  input logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 24'd0) else $error("outside not zero");

  a_no_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !$rose(out_tvalid))
    else $error("result from write");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready) else $error("compute overlap");

endmodule

bind bicubic_image_scaler_unit bisc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tuser(out_tuser), .out_tdata(out_tdata)
);
